// ----- rtl/isrch_pkg.sv -----
// Package with sizes, codes and the controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package isrch_pkg;

  localparam int DEPTH = 1024;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;
  localparam int RW = 32 + AW;
  localparam int DCW = $clog2(AW + 1);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] SEL_LO  = 2'd0;
  localparam logic [1:0] SEL_HI  = 2'd1;
  localparam logic [1:0] SEL_POS = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic       start;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_a;
    logic       cap_b;
    logic       mul;
    logic       div_step;
    logic       pos_lo;
    logic       pos_q;
    logic       move;
    logic       emit_hit;
    logic       emit_miss;
  } isrch_cmd_t;

  typedef struct packed {
    logic lo_gt_hi;
    logic out_range;
    logic ends_eq;
    logic hit;
    logic less;
    logic out_free;
  } isrch_sts_t;

endpackage

`default_nettype wire

// ----- rtl/interpolation_search.sv -----
// Top level of the interpolation search block: controller, datapath and stream ports.
//
//   Port group  Direction  Beat contents
//   s_*         in         action, item_value; one beat per clear, append or search
//   m_*         out        found, found_index; one beat per search
//
// Clear and append are done when idle. Each search probe reads its end values via the
// single memory read port and, if in range, its probe value after the bit-per-cycle
// divider for AW = 10 bits unless the ends match. No input beat is taken in a search.
// Reset clears the element count and the output valid flag; the memory is not cleared.
// A finished result waits in the output register while new beats are taken; the block
// stalls only at the end of a search while an earlier result has not been taken.
`timescale 1ns / 1ps
`default_nettype none

module interpolation_search
  import isrch_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [39:0] s_tdata,   // action [1:0], item_value [33:2], zero fill
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [15:0] m_tdata    // found [0], found_index [10:1], zero fill
);

  isrch_cmd_t    cmd;
  isrch_sts_t    sts;
  logic          out_found;
  logic [AW-1:0] out_index;

  isrch_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .action   (s_tdata[1:0]),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  isrch_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (s_tdata[33:2]),
    .out_take  (m_tready),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_found (out_found),
    .out_index (out_index)
  );

  assign m_tdata = {{(15-AW){1'b0}}, out_index, out_found};

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_hit || cmd.emit_miss) |-> (!m_tvalid || m_tready))
    else $error("Result loaded while the output register was still full.");

  a_idle_no_read: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !cmd.rd_en)
    else $error("Memory read issued while the block was idle.");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.emit_miss) |-> (m_tvalid && !m_tdata[0] && m_tdata[10:1] == '0))
    else $error("A missed search produced a nonzero index.");

endmodule

`default_nettype wire

// ----- rtl/isrch_datapath.sv -----
// Datapath: element memory, search bounds, probe multiply and divide, result register.
`timescale 1ns / 1ps
`default_nettype none

module isrch_datapath
  import isrch_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  wire isrch_cmd_t   cmd,
  input  wire signed [31:0] value,
  input  wire               out_take,
  output isrch_sts_t        sts,
  output logic              out_valid,
  output logic              out_found,
  output logic [AW-1:0]     out_index
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;
  logic [AW-1:0]      raddr;
  logic [CW-1:0]      count;
  logic               can_add;

  logic signed [31:0] key;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [CW:0] lo;
  logic signed [CW:0] hi;
  logic signed [CW:0] pos;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      dsh;
  logic [AW-1:0]      q;

  logic [32:0]        kd_full;
  logic [32:0]        den_full;
  logic signed [CW:0] span_full;
  logic [RW-1:0]      prod;
  logic               ge;
  logic [AW:0]        q_shift;

  assign can_add   = count < CW'(DEPTH);
  assign kd_full   = {key[31], key} - {a[31], a};
  assign den_full  = {b[31], b} - {a[31], a};
  assign span_full = hi - lo;
  assign prod      = RW'(kd_full[31:0]) * RW'(span_full[AW-1:0]);
  assign ge        = rem >= dsh;
  assign q_shift   = {q, ge};

  always_comb begin
    case (cmd.rd_sel)
      SEL_LO:  raddr = lo[AW-1:0];
      SEL_HI:  raddr = hi[AW-1:0];
      SEL_POS: raddr = pos[AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign sts.lo_gt_hi  = lo > hi;
  assign sts.out_range = (key < a) || (key > rdata);
  assign sts.ends_eq   = a == rdata;
  assign sts.hit       = rdata == key;
  assign sts.less      = rdata < key;
  assign sts.out_free  = !out_valid || out_take;

  always_ff @(posedge clk) begin
    if (cmd.append && can_add) begin
      mem[count[AW-1:0]] <= value;
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.append && can_add) begin
        count <= count + CW'(1);
      end
      if (cmd.emit_hit || cmd.emit_miss) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= value;
      lo  <= '0;
      hi  <= $signed({1'b0, count}) - (CW+1)'(1);
    end
    if (cmd.move) begin
      if (sts.less) begin
        lo <= pos + (CW+1)'(1);
      end else begin
        hi <= pos - (CW+1)'(1);
      end
    end
    if (cmd.cap_a) begin
      a <= rdata;
    end
    if (cmd.cap_b) begin
      b <= rdata;
    end
    if (cmd.mul) begin
      rem <= prod;
      dsh <= {1'b0, den_full[31:0], {(AW-1){1'b0}}};
      q   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      q   <= q_shift[AW-1:0];
    end
    if (cmd.pos_lo) begin
      pos <= lo;
    end
    if (cmd.pos_q) begin
      pos <= lo + $signed({{(CW+1-AW){1'b0}}, q});
    end
    if (cmd.emit_hit || cmd.emit_miss) begin
      out_found <= cmd.emit_hit;
      out_index <= cmd.emit_hit ? pos[AW-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/isrch_ctrl.sv -----
// Controller state machine that sequences store updates and search probes.
`timescale 1ns / 1ps
`default_nettype none

module isrch_ctrl
  import isrch_pkg::*;
(
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  input  wire [1:0]       action,
  output logic            in_ready,
  input  wire isrch_sts_t sts,
  output isrch_cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LOOP = 4'd1;
  localparam logic [3:0] ST_RDA  = 4'd2;
  localparam logic [3:0] ST_CHK  = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_POSQ = 4'd6;
  localparam logic [3:0] ST_RDV  = 4'd7;
  localparam logic [3:0] ST_CMP  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]     state;
  logic [3:0]     state_next;
  logic [DCW-1:0] cnt;
  logic [DCW-1:0] cnt_next;
  logic           found;
  logic           found_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    found_next = found;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (action)
            ACT_CLEAR:  cmd.clear = 1'b1;
            ACT_APPEND: cmd.append = 1'b1;
            ACT_SEARCH: begin
              cmd.start  = 1'b1;
              found_next = 1'b0;
              state_next = ST_LOOP;
            end
            default: ;
          endcase
        end
      end
      ST_LOOP: begin
        if (sts.lo_gt_hi) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = SEL_LO;
          state_next = ST_RDA;
        end
      end
      ST_RDA: begin
        cmd.cap_a  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_HI;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        cmd.cap_b = 1'b1;
        if (sts.out_range) begin
          state_next = ST_DONE;
        end else if (sts.ends_eq) begin
          cmd.pos_lo = 1'b1;
          state_next = ST_RDV;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + DCW'(1);
        if (cnt == DCW'(AW - 1)) begin
          state_next = ST_POSQ;
        end
      end
      ST_POSQ: begin
        cmd.pos_q  = 1'b1;
        state_next = ST_RDV;
      end
      ST_RDV: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = SEL_POS;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (sts.hit) begin
          found_next = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.move   = 1'b1;
          state_next = ST_LOOP;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit_hit  = found;
          cmd.emit_miss = !found;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      found <= found_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for interpolation_search: random store loads and searches checked against a predictor.
`timescale 1ns / 1ps

class search_scoreboard;
  typedef struct {
    bit       found;
    bit [9:0] index;
  } search_result_t;

  int             store [isrch_pkg::DEPTH];
  int             held;
  search_result_t awaited [$];
  int             errors;

  function new();
    held = 0;
    errors = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function search_result_t lookup(int key);
    search_result_t r;
    longint lo, hi, a, b, pos, v;
    r.found = 0;
    r.index = '0;
    lo = 0;
    hi = held - 1;
    while (lo <= hi) begin
      a = store[lo];
      b = store[hi];
      if (key < a || key > b) break;
      if (a == b) pos = lo;
      else pos = lo + ((longint'(key) - a) * (hi - lo)) / (b - a);
      v = store[pos];
      if (v == key) begin
        r.found = 1;
        r.index = pos[9:0];
        return r;
      end
      if (v < key) lo = pos + 1;
      else hi = pos - 1;
    end
    return r;
  endfunction

  function void note_beat(logic [1:0] act, logic [31:0] val);
    case (act)
      isrch_pkg::ACT_CLEAR: held = 0;
      isrch_pkg::ACT_APPEND: begin
        if (held < isrch_pkg::DEPTH) begin
          store[held] = val;
          held++;
        end
      end
      isrch_pkg::ACT_SEARCH: awaited.push_back(lookup(val));
      default: ;
    endcase
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  task check_result(bit found, bit [9:0] index, bit [4:0] fill);
    search_result_t e;
    if (awaited.size() == 0) begin
      report($sformatf("unexpected result found=%0d index=%0d", found, index));
      return;
    end
    e = awaited.pop_front();
    if (found !== e.found)
      report($sformatf("found %0d, expected %0d", found, e.found));
    if (index !== e.index)
      report($sformatf("index %0d, expected %0d", index, e.index));
    if (fill !== 5'd0)
      report($sformatf("nonzero fill bits %b", fill));
  endtask
endclass

module tb_top;
  import isrch_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 5_000_000;
  localparam int         RANDOM_ITEMS = 750;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [15:0] m_tdata;

  bit               calm = 0;
  int               cycles = 0;
  int               sent = 0;
  int               loaded [$];
  search_scoreboard sb;

  interpolation_search dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[0], m_tdata[10:1], m_tdata[15:11]);
  end

  task automatic send_beat(input logic [1:0] act, input logic [31:0] val);
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {6'b0, val, act};
    do @(posedge clk); while (!s_tready);
    sb.note_beat(act, val);
    sent++;
    @(negedge clk);
  endtask

  task automatic load_run(input int n, input bit sorted);
    int     mode;
    longint cur;
    longint step_max;
    mode = $urandom_range(2);
    if (mode == 2) cur = -64'sd2147483648 + $urandom_range(1000);
    else cur = longint'($signed($urandom()));
    if (mode == 0) step_max = 2;
    else if (mode == 1) step_max = 1000;
    else step_max = 64'd4294967295 / (n + 1);
    for (int i = 0; i < n; i++) begin
      if (sorted) begin
        cur = cur + $urandom_range(32'(step_max));
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end else begin
        cur = longint'($signed($urandom()));
      end
      send_beat(ACT_APPEND, cur[31:0]);
      if (loaded.size() < DEPTH) loaded.push_back(int'(cur));
    end
  endtask

  function automatic logic [31:0] pick_key();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (loaded.size() == 0 || sel >= 90) return $urandom();
    if (sel >= 80) return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
    v = loaded[$urandom_range(loaded.size() - 1)];
    if (sel >= 60) return v + (($urandom_range(1)) ? 1 : -1);
    return v;
  endfunction

  initial begin
    int n;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;
    @(negedge clk);

    send_beat(ACT_SEARCH, 32'd0);
    send_beat(ACT_APPEND, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'h7fff_ffff);
    send_beat(ACT_CLEAR, 32'hffff_ffff);
    send_beat(ACT_APPEND, 32'd5);
    send_beat(ACT_APPEND, 32'd5);
    send_beat(ACT_APPEND, 32'd5);
    send_beat(ACT_SEARCH, 32'd5);
    send_beat(ACT_SEARCH, 32'd4);
    send_beat(ACT_CLEAR, 32'd0);
    send_beat(ACT_APPEND, 32'h8000_0000);
    send_beat(ACT_APPEND, -32'sd5);
    send_beat(ACT_APPEND, 32'd0);
    send_beat(ACT_APPEND, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'h7fff_ffff);
    send_beat(ACT_SEARCH, 32'h8000_0000);
    send_beat(ACT_SEARCH, 32'd1);
    send_beat(ACT_UNUSED, 32'h5a5a_a5a5);
    send_beat(ACT_SEARCH, 32'd0);
    send_beat(ACT_CLEAR, 32'd0);
    send_beat(ACT_APPEND, 32'd9);
    send_beat(ACT_APPEND, -32'sd3);
    send_beat(ACT_APPEND, 32'd4);
    send_beat(ACT_SEARCH, 32'd4);
    send_beat(ACT_SEARCH, -32'sd3);

    sent = 0;
    for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
      calm = (phase >= 10 && phase < 15);
      if ($urandom_range(9) != 0) begin
        send_beat(ACT_CLEAR, $urandom());
        loaded.delete();
      end
      if (phase == 6) begin
        load_run(DEPTH + 6, 1);
        sent = sent - DEPTH - 6;
      end else begin
        n = $urandom_range(99);
        if (n < 5) n = 0;
        else if (n < 85) n = $urandom_range(1, 32);
        else n = $urandom_range(33, 200);
        load_run(n, $urandom_range(9) != 0);
      end
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(19) == 0) begin
          send_beat(ACT_UNUSED, $urandom());
          sent--;
        end
        send_beat(ACT_SEARCH, pick_key());
      end
    end
    calm = 0;
    s_tvalid = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
